// ===== rtl/usb_config_descriptor_parser_macros.svh =====
// assertion macros for the configuration descriptor parser
`ifndef USB_CONFIG_DESCRIPTOR_PARSER_MACROS_SVH
`define USB_CONFIG_DESCRIPTOR_PARSER_MACROS_SVH

// same-cycle implication, disabled in reset
`define UCDP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ucdp assertion failed");

// next-cycle implication, disabled in reset
`define UCDP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ucdp assertion failed");

`endif

// ===== rtl/ucdp_pkg.sv =====
// shared types and constants of the configuration descriptor parser
package ucdp_pkg;

    localparam logic [1:0] KIND_IFACE = 2'd0;
    localparam logic [1:0] KIND_ENDP  = 2'd1;
    localparam logic [1:0] KIND_EXTRA = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic ERR_TRUNC    = 1'b0;
    localparam logic ERR_NOT_CONF = 1'b1;

    localparam logic CFG_MAX_EP   = 1'b0;
    localparam logic CFG_CAPACITY = 1'b1;

    localparam logic [7:0] DESC_CONFIG = 8'd2;
    localparam logic [7:0] DESC_IFACE  = 8'd4;
    localparam logic [7:0] DESC_ENDP   = 8'd5;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  record_kind;
        logic        error_code;
        logic [7:0]  config_value;
        logic [7:0]  iface_number;
        logic [7:0]  alt_setting;
        logic [4:0]  endpoint_count;
        logic [3:0]  endpoint_slot;
        logic [7:0]  endpoint_address;
        logic [7:0]  endpoint_attributes;
        logic [15:0] max_packet;
        logic [7:0]  poll_interval;
        logic [7:0]  extra_value;
    } t_rec;

    typedef struct packed {
        logic space2;
        logic valid;
    } t_fifo_stat;

    function automatic t_rec mk_error(input logic code);
        t_rec r;
        r = '0;
        r.record_kind = KIND_ERROR;
        r.error_code  = code;
        return r;
    endfunction

    function automatic t_rec mk_extra(input logic [7:0] cfg, input logic [15:0] iface,
                                      input logic [7:0] val);
        t_rec r;
        r = '0;
        r.record_kind  = KIND_EXTRA;
        r.config_value = cfg;
        r.iface_number = iface[15:8];
        r.alt_setting  = iface[7:0];
        r.extra_value  = val;
        return r;
    endfunction

    function automatic t_rec mk_iface(input logic [7:0] cfg, input logic [15:0] iface,
                                      input logic [4:0] total);
        t_rec r;
        r = '0;
        r.record_kind    = KIND_IFACE;
        r.config_value   = cfg;
        r.iface_number   = iface[15:8];
        r.alt_setting    = iface[7:0];
        r.endpoint_count = total;
        return r;
    endfunction

    function automatic t_rec mk_endp(input logic [7:0] cfg, input logic [15:0] iface,
                                     input logic [4:0] total, input logic [3:0] slot,
                                     input logic [39:0] fields);
        t_rec r;
        r = '0;
        r.record_kind         = KIND_ENDP;
        r.config_value        = cfg;
        r.iface_number        = iface[15:8];
        r.alt_setting         = iface[7:0];
        r.endpoint_count      = total;
        r.endpoint_slot       = slot;
        r.endpoint_address    = fields[7:0];
        r.endpoint_attributes = fields[15:8];
        r.max_packet          = fields[31:16];
        r.poll_interval       = fields[39:32];
        return r;
    endfunction

endpackage

// ===== rtl/ucdp_res_fifo.sv =====
// result queue taking up to two words per cycle and giving one
module ucdp_res_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_push_cnt,
    input  ucdp_pkg::t_rec      i_rec0,
    input  ucdp_pkg::t_rec      i_rec1,
    output ucdp_pkg::t_fifo_stat o_stat,
    input  logic                i_pop,
    output ucdp_pkg::t_rec      o_rec
);

    ucdp_pkg::t_rec                       r_mem [ucdp_pkg::FIFO_DEPTH];
    logic [ucdp_pkg::FIFO_PTR_W-1:0]      r_wr;
    logic [ucdp_pkg::FIFO_PTR_W-1:0]      r_rd;
    logic [ucdp_pkg::FIFO_CNT_W-1:0]      r_cnt;
    logic [ucdp_pkg::FIFO_PTR_W-1:0]      wr1;
    logic                                 pop_ok;

    assign wr1    = r_wr + ucdp_pkg::FIFO_PTR_W'(1);
    assign pop_ok = i_pop && (r_cnt != '0);

    assign o_stat.valid  = (r_cnt != '0);
    assign o_stat.space2 = (r_cnt <= ucdp_pkg::FIFO_CNT_W'(ucdp_pkg::FIFO_DEPTH - 2));
    assign o_rec         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ucdp_pkg::FIFO_DEPTH; i++) begin
            if (i_push_cnt != 2'd0 && r_wr == ucdp_pkg::FIFO_PTR_W'(i)) begin
                r_mem[i] <= i_rec0;
            end
            if (i_push_cnt == 2'd2 && wr1 == ucdp_pkg::FIFO_PTR_W'(i)) begin
                r_mem[i] <= i_rec1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + ucdp_pkg::FIFO_PTR_W'(i_push_cnt);
            r_rd  <= r_rd + ucdp_pkg::FIFO_PTR_W'(pop_ok);
            r_cnt <= r_cnt + ucdp_pkg::FIFO_CNT_W'(i_push_cnt)
                     - ucdp_pkg::FIFO_CNT_W'(pop_ok);
        end
    end

endmodule

// ===== rtl/usb_config_descriptor_parser.sv =====
// throughput: one byte per cycle while the result queue has two free slots; a byte giving two
//   words is absorbed by a four-word result queue, so the output port sets the long-run rate
// input register, one parse step, result queue; new bytes wait while the queue lacks two slots
// reset: synchronous active low, clears parse state and queue, max_endpoints 8, capacity 256
module usb_config_descriptor_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_of_buffer,
    input  logic [10:0] i_buffer_length,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_record_kind,
    output logic        o_error_code,
    output logic [7:0]  o_config_value,
    output logic [7:0]  o_iface_number,
    output logic [7:0]  o_alt_setting,
    output logic [4:0]  o_endpoint_count,
    output logic [3:0]  o_endpoint_slot,
    output logic [7:0]  o_endpoint_address,
    output logic [7:0]  o_endpoint_attributes,
    output logic [15:0] o_max_packet,
    output logic [7:0]  o_poll_interval,
    output logic [7:0]  o_extra_value
);

    localparam logic [2:0] PH_CONF  = 3'd0;
    localparam logic [2:0] PH_IFACE = 3'd1;
    localparam logic [2:0] PH_ENDP  = 3'd2;
    localparam logic [2:0] PH_DONE  = 3'd3;
    localparam logic [2:0] PH_HALT  = 3'd4;

    localparam logic [10:0] BOFF_MAX    = 11'h7FF;

    // configuration
    logic [4:0]  r_max_ep;
    logic [9:0]  r_cap;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_first;
    logic [10:0] r_in_len;

    // parse state
    logic [10:0] r_boff,    n_boff;
    logic [7:0]  r_doff,    n_doff;
    logic [7:0]  r_dlen,    n_dlen;
    logic [7:0]  r_dkind,   n_dkind;
    logic [2:0]  r_phase,   n_phase;
    logic [7:0]  r_ifl,     n_ifl;
    logic [4:0]  r_epl,     n_epl;
    logic [7:0]  r_config,  n_config;
    logic [15:0] r_iface,   n_iface;
    logic [9:0]  r_xused,   n_xused;
    logic        r_xkeep,   n_xkeep;
    logic [39:0] r_epf,     n_epf;
    logic [7:0]  r_held,    n_held;
    logic [4:0]  r_eptotal, n_eptotal;

    ucdp_pkg::t_fifo_stat fifo_stat;
    ucdp_pkg::t_rec       recs [2];
    ucdp_pkg::t_rec       head;
    logic [1:0]           push_cnt;
    logic                 proc_fire;

    assign proc_fire  = r_in_valid && fifo_stat.space2;
    assign o_in_ready = !r_in_valid || proc_fire;

    always_comb begin
        logic [10:0] pos;
        logic        last;
        logic        stop;
        logic [4:0]  lim;
        logic [7:0]  b;
        logic [7:0]  doff_inc;
        logic [4:0]  slot_w;
        n_boff    = r_boff;
        n_doff    = r_doff;
        n_dlen    = r_dlen;
        n_dkind   = r_dkind;
        n_phase   = r_phase;
        n_ifl     = r_ifl;
        n_epl     = r_epl;
        n_config  = r_config;
        n_iface   = r_iface;
        n_xused   = r_xused;
        n_xkeep   = r_xkeep;
        n_epf     = r_epf;
        n_held    = r_held;
        n_eptotal = r_eptotal;
        push_cnt  = 2'd0;
        recs[0]   = '0;
        recs[1]   = '0;
        b         = r_in_byte;
        pos       = '0;
        last      = 1'b0;
        stop      = 1'b0;
        doff_inc  = '0;
        slot_w    = '0;
        if (r_max_ep == 5'd0) begin
            lim = 5'd1;
        end else if (r_max_ep > 5'd16) begin
            lim = 5'd16;
        end else begin
            lim = r_max_ep;
        end
        if (proc_fire) begin
            if (r_in_first) begin
                n_boff  = '0;
                n_doff  = '0;
                n_phase = PH_CONF;
                n_ifl   = '0;
                n_epl   = '0;
                n_xused = '0;
                n_xkeep = 1'b0;
            end
            pos = n_boff;
            if (n_boff != BOFF_MAX) begin
                n_boff = n_boff + 11'd1;
            end
            if (n_phase < PH_DONE && pos < r_in_len) begin
                last = ({1'b0, pos} + 12'd1) >= {1'b0, r_in_len};
                if (n_doff == 8'd0) begin
                    // length byte
                    if (b < 8'd2 || ({1'b0, pos} + {4'b0, b}) > {1'b0, r_in_len}) begin
                        n_phase = PH_HALT;
                        recs[push_cnt[0]] = ucdp_pkg::mk_error(ucdp_pkg::ERR_TRUNC);
                        push_cnt = push_cnt + 2'd1;
                    end else begin
                        n_dlen = b;
                        n_held = b;
                        n_doff = 8'd1;
                        if (n_phase == PH_CONF) begin
                            n_ifl    = '0;
                            n_config = '0;
                        end
                        if (last) begin
                            n_phase = PH_HALT;
                            recs[push_cnt[0]] = ucdp_pkg::mk_error(ucdp_pkg::ERR_TRUNC);
                            push_cnt = push_cnt + 2'd1;
                        end
                    end
                end else begin
                    if (n_doff == 8'd1) begin
                        // type byte
                        n_dkind = b;
                        if (n_phase == PH_CONF && b != ucdp_pkg::DESC_CONFIG) begin
                            n_phase = PH_HALT;
                            n_doff  = '0;
                            stop    = 1'b1;
                            recs[push_cnt[0]] = ucdp_pkg::mk_error(ucdp_pkg::ERR_NOT_CONF);
                            push_cnt = push_cnt + 2'd1;
                        end else begin
                            if (n_phase == PH_IFACE && b == ucdp_pkg::DESC_IFACE) begin
                                n_iface   = '0;
                                n_eptotal = '0;
                            end
                            if (n_phase == PH_ENDP && b != ucdp_pkg::DESC_ENDP) begin
                                n_xkeep = ({1'b0, n_xused} + {3'b0, r_dlen}) <= {1'b0, r_cap};
                                if (r_dlen == 8'd2 && last) begin
                                    n_xkeep = 1'b0;
                                end
                                if (n_xkeep) begin
                                    n_xused = n_xused + {2'b0, r_dlen};
                                    recs[0] = ucdp_pkg::mk_extra(n_config, n_iface, r_held);
                                    recs[1] = ucdp_pkg::mk_extra(n_config, n_iface, b);
                                    push_cnt = 2'd2;
                                end
                            end
                        end
                    end else if (n_phase == PH_CONF) begin
                        if (n_doff == 8'd4) begin
                            n_ifl = b;
                        end else if (n_doff == 8'd5) begin
                            n_config = b;
                        end
                    end else if (n_phase == PH_IFACE) begin
                        if (r_dkind == ucdp_pkg::DESC_IFACE) begin
                            if (n_doff == 8'd2) begin
                                n_iface[15:8] = b;
                            end else if (n_doff == 8'd3) begin
                                n_iface[7:0] = b;
                            end else if (n_doff == 8'd4) begin
                                n_eptotal = ({3'b0, lim} < b) ? lim : b[4:0];
                            end
                        end
                    end else begin
                        if (r_dkind == ucdp_pkg::DESC_ENDP) begin
                            unique case (n_doff)
                                8'd2:    n_epf[7:0]   = b;
                                8'd3:    n_epf[15:8]  = b;
                                8'd4:    n_epf[23:16] = b;
                                8'd5:    n_epf[31:24] = b;
                                8'd6:    n_epf[39:32] = b;
                                default: n_epf        = n_epf;
                            endcase
                        end else if (n_xkeep) begin
                            recs[push_cnt[0]] = ucdp_pkg::mk_extra(n_config, n_iface, b);
                            push_cnt = push_cnt + 2'd1;
                        end
                    end

                    if (!stop) begin
                        // end of descriptor
                        doff_inc = n_doff + 8'd1;
                        n_doff   = doff_inc;
                        if (doff_inc >= r_dlen) begin
                            n_doff = '0;
                            if (n_phase == PH_CONF) begin
                                n_phase = (n_ifl != 8'd0) ? PH_IFACE : PH_DONE;
                            end else if (n_phase == PH_IFACE) begin
                                if (n_dkind == ucdp_pkg::DESC_IFACE) begin
                                    recs[push_cnt[0]] =
                                        ucdp_pkg::mk_iface(n_config, n_iface, n_eptotal);
                                    push_cnt = push_cnt + 2'd1;
                                    n_ifl   = n_ifl - 8'd1;
                                    n_xused = '0;
                                    n_epl   = n_eptotal;
                                    if (n_eptotal != 5'd0) begin
                                        n_phase = PH_ENDP;
                                    end else begin
                                        n_phase = (n_ifl != 8'd0) ? PH_IFACE : PH_DONE;
                                    end
                                end
                            end else if (n_dkind == ucdp_pkg::DESC_ENDP) begin
                                slot_w = n_eptotal - n_epl;
                                recs[push_cnt[0]] = ucdp_pkg::mk_endp(n_config, n_iface,
                                                                      n_eptotal, slot_w[3:0],
                                                                      n_epf);
                                push_cnt = push_cnt + 2'd1;
                                n_epl = n_epl - 5'd1;
                                if (n_epl == 5'd0) begin
                                    n_phase = (n_ifl != 8'd0) ? PH_IFACE : PH_DONE;
                                end
                            end
                        end
                        if (last && n_phase < PH_DONE) begin
                            n_phase = PH_HALT;
                            recs[push_cnt[0]] = ucdp_pkg::mk_error(ucdp_pkg::ERR_TRUNC);
                            push_cnt = push_cnt + 2'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ep <= 5'd8;
            r_cap    <= 10'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ucdp_pkg::CFG_MAX_EP:   r_max_ep <= i_cfg_data[4:0];
                ucdp_pkg::CFG_CAPACITY: r_cap    <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first_of_buffer;
            r_in_len   <= i_buffer_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_boff     <= '0;
            r_doff     <= '0;
            r_dlen     <= '0;
            r_dkind    <= '0;
            r_phase    <= PH_CONF;
            r_ifl      <= '0;
            r_epl      <= '0;
            r_config   <= '0;
            r_iface    <= '0;
            r_xused    <= '0;
            r_xkeep    <= 1'b0;
            r_epf      <= '0;
            r_held     <= '0;
            r_eptotal  <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_boff    <= n_boff;
            r_doff    <= n_doff;
            r_dlen    <= n_dlen;
            r_dkind   <= n_dkind;
            r_phase   <= n_phase;
            r_ifl     <= n_ifl;
            r_epl     <= n_epl;
            r_config  <= n_config;
            r_iface   <= n_iface;
            r_xused   <= n_xused;
            r_xkeep   <= n_xkeep;
            r_epf     <= n_epf;
            r_held    <= n_held;
            r_eptotal <= n_eptotal;
        end
    end

    ucdp_res_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_rec0     (recs[0]),
        .i_rec1     (recs[1]),
        .o_stat     (fifo_stat),
        .i_pop      (i_out_ready),
        .o_rec      (head)
    );

    assign o_out_valid           = fifo_stat.valid;
    assign o_record_kind         = head.record_kind;
    assign o_error_code          = head.error_code;
    assign o_config_value        = head.config_value;
    assign o_iface_number        = head.iface_number;
    assign o_alt_setting         = head.alt_setting;
    assign o_endpoint_count      = head.endpoint_count;
    assign o_endpoint_slot       = head.endpoint_slot;
    assign o_endpoint_address    = head.endpoint_address;
    assign o_endpoint_attributes = head.endpoint_attributes;
    assign o_max_packet          = head.max_packet;
    assign o_poll_interval       = head.poll_interval;
    assign o_extra_value         = head.extra_value;

endmodule

// ===== rtl/ucdp_checker.sv =====
// port-level checks on the parser's result words, bound to the top level
`include "usb_config_descriptor_parser_macros.svh"

module ucdp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_record_kind,
    input logic        o_error_code,
    input logic [7:0]  o_config_value,
    input logic [7:0]  o_iface_number,
    input logic [7:0]  o_alt_setting,
    input logic [4:0]  o_endpoint_count,
    input logic [3:0]  o_endpoint_slot,
    input logic [15:0] o_max_packet,
    input logic [7:0]  o_extra_value
);

    `UCDP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    `UCDP_ASSERT_IMP(a_error_clean, i_clk, i_rst_n, o_out_valid && o_record_kind == ucdp_pkg::KIND_ERROR, o_config_value == 8'd0 && o_iface_number == 8'd0 && o_alt_setting == 8'd0 && o_endpoint_count == 5'd0)

    `UCDP_ASSERT_IMP(a_code_only_error, i_clk, i_rst_n, o_out_valid && o_record_kind != ucdp_pkg::KIND_ERROR, o_error_code == 1'b0)

    `UCDP_ASSERT_IMP(a_slot_in_range, i_clk, i_rst_n, o_out_valid && o_record_kind == ucdp_pkg::KIND_ENDP, {1'b0, o_endpoint_slot} < o_endpoint_count)

    `UCDP_ASSERT_IMP(a_extra_clean, i_clk, i_rst_n, o_out_valid && o_record_kind != ucdp_pkg::KIND_EXTRA, o_extra_value == 8'd0 && (o_record_kind == ucdp_pkg::KIND_ENDP || o_max_packet == 16'd0))

endmodule

bind usb_config_descriptor_parser ucdp_checker u_ucdp_checker (.*);

// ===== tb/tb_usb_config_descriptor_parser.sv =====
// testbench for the configuration descriptor parser: record predictor, byte driver, record checker
typedef enum logic [2:0] {
    SEEK_CONFIG,
    SEEK_IFACE,
    SEEK_ENDP,
    PARSE_DONE,
    PARSE_HALTED
} t_parse_phase;

typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} t_rx_mode;

class record_scoreboard;
    ucdp_pkg::t_rec pending_records[$];
    int           mismatches;
    int           seen_by_kind[4];
    logic [4:0]   ep_limit_reg;
    logic [9:0]   extra_cap;
    logic [10:0]  buf_pos;
    logic [7:0]   desc_pos;
    logic [7:0]   desc_len;
    logic [7:0]   desc_type;
    logic [7:0]   len_byte;
    logic [7:0]   ifaces_left;
    logic [7:0]   cfg_val;
    logic [4:0]   eps_left;
    logic [4:0]   ep_total;
    logic [15:0]  iface_id;
    logic [9:0]   extra_fill;
    logic         keep_extra;
    logic [39:0]  ep_bytes;
    t_parse_phase phase;

    function new();
        mismatches   = 0;
        seen_by_kind = '{0, 0, 0, 0};
        ep_limit_reg = 5'd8;
        extra_cap    = 10'd256;
        buf_pos      = '0;
        desc_pos     = '0;
        desc_len     = '0;
        desc_type    = '0;
        len_byte     = '0;
        ifaces_left  = '0;
        cfg_val      = '0;
        eps_left     = '0;
        ep_total     = '0;
        iface_id     = '0;
        extra_fill   = '0;
        keep_extra   = 1'b0;
        ep_bytes     = '0;
        phase        = SEEK_CONFIG;
    endfunction

    function void set_register(logic idx, logic [9:0] val);
        if (idx == ucdp_pkg::CFG_MAX_EP) begin
            ep_limit_reg = val[4:0];
        end else begin
            extra_cap = val;
        end
    endfunction

    function void push_record(logic [1:0] kind, logic code, logic [7:0] val);
        ucdp_pkg::t_rec r;
        r = '0;
        r.record_kind = kind;
        if (kind == ucdp_pkg::KIND_ERROR) begin
            r.error_code = code;
        end else begin
            r.config_value = cfg_val;
            r.iface_number = iface_id[15:8];
            r.alt_setting  = iface_id[7:0];
            if (kind == ucdp_pkg::KIND_EXTRA) begin
                r.extra_value = val;
            end else begin
                r.endpoint_count = ep_total;
                if (kind == ucdp_pkg::KIND_ENDP) begin
                    r.endpoint_slot       = 4'(ep_total - eps_left);
                    r.endpoint_address    = ep_bytes[7:0];
                    r.endpoint_attributes = ep_bytes[15:8];
                    r.max_packet          = ep_bytes[31:16];
                    r.poll_interval       = ep_bytes[39:32];
                end
            end
        end
        pending_records.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b, logic first, logic [10:0] len);
        int pos;
        int lim;
        bit at_end;
        if (first) begin
            buf_pos     = '0;
            desc_pos    = '0;
            phase       = SEEK_CONFIG;
            ifaces_left = '0;
            eps_left    = '0;
            extra_fill  = '0;
            keep_extra  = 1'b0;
        end
        pos = buf_pos;
        if (buf_pos != 11'h7FF) buf_pos++;
        if (phase >= PARSE_DONE || pos >= len) return;
        at_end = (pos + 1 >= len);

        if (desc_pos == 0) begin
            if (b < 2 || pos + b > len) begin
                phase = PARSE_HALTED;
                push_record(ucdp_pkg::KIND_ERROR, ucdp_pkg::ERR_TRUNC, 8'd0);
                return;
            end
            desc_len = b;
            len_byte = b;
            desc_pos = 8'd1;
            if (phase == SEEK_CONFIG) begin
                ifaces_left = '0;
                cfg_val     = '0;
            end
            if (at_end) begin
                phase = PARSE_HALTED;
                push_record(ucdp_pkg::KIND_ERROR, ucdp_pkg::ERR_TRUNC, 8'd0);
            end
            return;
        end

        if (desc_pos == 1) begin
            desc_type = b;
            if (phase == SEEK_CONFIG && b != ucdp_pkg::DESC_CONFIG) begin
                phase    = PARSE_HALTED;
                desc_pos = '0;
                push_record(ucdp_pkg::KIND_ERROR, ucdp_pkg::ERR_NOT_CONF, 8'd0);
                return;
            end
            if (phase == SEEK_IFACE && b == ucdp_pkg::DESC_IFACE) begin
                iface_id = '0;
                ep_total = '0;
            end
            if (phase == SEEK_ENDP && b != ucdp_pkg::DESC_ENDP) begin
                keep_extra = (int'(extra_fill) + int'(desc_len) <= int'(extra_cap));
                if (desc_len == 2 && at_end) keep_extra = 1'b0;
                if (keep_extra) begin
                    extra_fill = extra_fill + 10'(desc_len);
                    push_record(ucdp_pkg::KIND_EXTRA, 1'b0, len_byte);
                    push_record(ucdp_pkg::KIND_EXTRA, 1'b0, b);
                end
            end
        end else if (phase == SEEK_CONFIG) begin
            if (desc_pos == 4) begin
                ifaces_left = b;
            end else if (desc_pos == 5) begin
                cfg_val = b;
            end
        end else if (phase == SEEK_IFACE) begin
            if (desc_type == ucdp_pkg::DESC_IFACE) begin
                lim = (ep_limit_reg == 0) ? 1 : (ep_limit_reg > 16 ? 16 : int'(ep_limit_reg));
                if (desc_pos == 2) begin
                    iface_id[15:8] = b;
                end else if (desc_pos == 3) begin
                    iface_id[7:0] = b;
                end else if (desc_pos == 4) begin
                    ep_total = (int'(b) > lim) ? 5'(lim) : 5'(b);
                end
            end
        end else begin
            if (desc_type == ucdp_pkg::DESC_ENDP) begin
                if (desc_pos >= 2 && desc_pos <= 6) ep_bytes[8 * (int'(desc_pos) - 2) +: 8] = b;
            end else if (keep_extra) begin
                push_record(ucdp_pkg::KIND_EXTRA, 1'b0, b);
            end
        end

        desc_pos++;
        if (desc_pos >= desc_len) begin
            desc_pos = '0;
            if (phase == SEEK_CONFIG) begin
                phase = (ifaces_left > 0) ? SEEK_IFACE : PARSE_DONE;
            end else if (phase == SEEK_IFACE) begin
                if (desc_type == ucdp_pkg::DESC_IFACE) begin
                    push_record(ucdp_pkg::KIND_IFACE, 1'b0, 8'd0);
                    ifaces_left--;
                    extra_fill = '0;
                    eps_left   = ep_total;
                    if (ep_total > 0) begin
                        phase = SEEK_ENDP;
                    end else begin
                        phase = (ifaces_left > 0) ? SEEK_IFACE : PARSE_DONE;
                    end
                end
            end else if (desc_type == ucdp_pkg::DESC_ENDP) begin
                push_record(ucdp_pkg::KIND_ENDP, 1'b0, 8'd0);
                eps_left--;
                if (eps_left == 0) phase = (ifaces_left > 0) ? SEEK_IFACE : PARSE_DONE;
            end
        end

        if (at_end && phase < PARSE_DONE) begin
            phase = PARSE_HALTED;
            push_record(ucdp_pkg::KIND_ERROR, ucdp_pkg::ERR_TRUNC, 8'd0);
        end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function void check_record(ucdp_pkg::t_rec got);
        ucdp_pkg::t_rec want;
        if (pending_records.size() == 0) begin
            $error("record of kind %0d arrived with none expected", got.record_kind);
            mismatches++;
            return;
        end
        want = pending_records.pop_front();
        seen_by_kind[want.record_kind]++;
        compare_field("record_kind", want.record_kind, got.record_kind);
        compare_field("error_code", want.error_code, got.error_code);
        compare_field("config_value", want.config_value, got.config_value);
        compare_field("iface_number", want.iface_number, got.iface_number);
        compare_field("alt_setting", want.alt_setting, got.alt_setting);
        compare_field("endpoint_count", want.endpoint_count, got.endpoint_count);
        compare_field("endpoint_slot", want.endpoint_slot, got.endpoint_slot);
        compare_field("endpoint_address", want.endpoint_address, got.endpoint_address);
        compare_field("endpoint_attributes", want.endpoint_attributes,
                      got.endpoint_attributes);
        compare_field("max_packet", want.max_packet, got.max_packet);
        compare_field("poll_interval", want.poll_interval, got.poll_interval);
        compare_field("extra_value", want.extra_value, got.extra_value);
    endfunction
endclass

module tb_usb_config_descriptor_parser;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [9:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_first_of_buffer;
    logic [10:0] i_buffer_length;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_record_kind;
    logic        o_error_code;
    logic [7:0]  o_config_value;
    logic [7:0]  o_iface_number;
    logic [7:0]  o_alt_setting;
    logic [4:0]  o_endpoint_count;
    logic [3:0]  o_endpoint_slot;
    logic [7:0]  o_endpoint_address;
    logic [7:0]  o_endpoint_attributes;
    logic [15:0] o_max_packet;
    logic [7:0]  o_poll_interval;
    logic [7:0]  o_extra_value;

    record_scoreboard sb = new();
    logic [7:0]       image[$];
    t_rx_mode         rx_mode = RX_ALWAYS;
    bit               gaps_on = 1'b0;
    int               burst_left = 0;
    bit               hold_req = 1'b0;
    int               hold_count = 0;
    int               phase_bytes = 0;
    int               bytes_sent = 0;
    int               buffers_sent = 0;
    int               reg_writes = 0;

    usb_config_descriptor_parser dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_data_byte           (i_data_byte),
        .i_first_of_buffer     (i_first_of_buffer),
        .i_buffer_length       (i_buffer_length),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_record_kind         (o_record_kind),
        .o_error_code          (o_error_code),
        .o_config_value        (o_config_value),
        .o_iface_number        (o_iface_number),
        .o_alt_setting         (o_alt_setting),
        .o_endpoint_count      (o_endpoint_count),
        .o_endpoint_slot       (o_endpoint_slot),
        .o_endpoint_address    (o_endpoint_address),
        .o_endpoint_attributes (o_endpoint_attributes),
        .o_max_packet          (o_max_packet),
        .o_poll_interval       (o_poll_interval),
        .o_extra_value         (o_extra_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: stall pattern per mode, plus long hold-offs on request
    initial begin
        int tick;
        tick = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (299) @(negedge i_clk);
                hold_req = 1'b0;
                hold_count++;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  i_out_ready = 1'b1;
                    RX_RANDOM:  i_out_ready = 1'($urandom_range(0, 1));
                    RX_PATTERN: i_out_ready = (tick % 7) < 4;
                    default:    i_out_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        ucdp_pkg::t_rec got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.record_kind         = o_record_kind;
                got.error_code          = o_error_code;
                got.config_value        = o_config_value;
                got.iface_number        = o_iface_number;
                got.alt_setting         = o_alt_setting;
                got.endpoint_count      = o_endpoint_count;
                got.endpoint_slot       = o_endpoint_slot;
                got.endpoint_address    = o_endpoint_address;
                got.endpoint_attributes = o_endpoint_attributes;
                got.max_packet          = o_max_packet;
                got.poll_interval       = o_poll_interval;
                got.extra_value         = o_extra_value;
                sb.check_record(got);
            end
        end
    end

    function automatic logic [7:0] rb();
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_kind(logic [7:0] avoid);
        logic [7:0] k;
        k = rb();
        if (k == avoid) k = 8'h24;
        return k;
    endfunction

    function automatic void push_desc(int len, logic [7:0] kind, logic [7:0] f2,
                                      logic [7:0] f3, logic [7:0] f4, logic [7:0] f5,
                                      logic [7:0] f6);
        int k;
        image.push_back(8'(len));
        image.push_back(kind);
        for (k = 2; k < len; k++) begin
            case (k)
                2:       image.push_back(f2);
                3:       image.push_back(f3);
                4:       image.push_back(f4);
                5:       image.push_back(f5);
                6:       image.push_back(f6);
                default: image.push_back(rb());
            endcase
        end
    endfunction

    function automatic void build_image();
        int n_if, clen, ilen, decl, n_ep, lim, j, k;
        lim = (sb.ep_limit_reg == 0) ? 1 : (sb.ep_limit_reg > 16 ? 16 : int'(sb.ep_limit_reg));
        image.delete();
        n_if = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        clen = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 12) : 9;
        push_desc(clen, ucdp_pkg::DESC_CONFIG, rb(), rb(), 8'(n_if), rb(), rb());
        if (clen < 5) n_if = 0;
        for (j = 0; j < n_if; j++) begin
            if ($urandom_range(0, 3) == 0)
                push_desc($urandom_range(2, 10), pick_kind(ucdp_pkg::DESC_IFACE),
                          rb(), rb(), rb(), rb(), rb());
            ilen = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 12) : 9;
            decl = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
            push_desc(ilen, ucdp_pkg::DESC_IFACE, rb(), rb(), 8'(decl), rb(), rb());
            n_ep = (ilen < 5) ? 0 : (decl > lim ? lim : decl);
            for (k = 0; k < n_ep; k++) begin
                while ($urandom_range(0, 2) == 0)
                    push_desc(($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                                          : $urandom_range(2, 12),
                              pick_kind(ucdp_pkg::DESC_ENDP), rb(), rb(), rb(), rb(), rb());
                push_desc(($urandom_range(0, 5) == 0) ? $urandom_range(2, 10) : 7,
                          ucdp_pkg::DESC_ENDP, rb(), rb(), rb(), rb(), rb());
            end
        end
        while (image.size() > 1024) image.pop_back();
    endfunction

    function automatic void build_noise();
        int n, i;
        image.delete();
        n = $urandom_range(1, 16);
        for (i = 0; i < n; i++) image.push_back(rb());
        image[0] = 8'($urandom_range(0, 12));
        if (n > 1 && $urandom_range(0, 1) == 1) image[1] = ucdp_pkg::DESC_CONFIG;
    endfunction

    task automatic send_byte(logic [7:0] b, logic first, logic [10:0] len);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        i_in_valid        = 1'b1;
        i_data_byte       = b;
        i_first_of_buffer = first;
        i_buffer_length   = len;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_byte(b, first, len);
        bytes_sent++;
    endtask

    task automatic send_image(int len, int n, bit noisy);
        int i;
        logic [7:0] b;
        logic first;
        for (i = 0; i < n; i++) begin
            b = (i < image.size()) ? image[i] : rb();
            first = (i == 0) || (noisy && $urandom_range(0, 7) == 0);
            send_byte(b, first, 11'(len));
            phase_bytes++;
        end
        buffers_sent++;
    endtask

    task automatic play_buffer();
        int total, len, n;
        bit noisy;
        noisy = ($urandom_range(0, 9) >= 8);
        if (noisy) begin
            build_noise();
        end else begin
            build_image();
        end
        total = image.size();
        n = total;
        len = total;
        case ($urandom_range(0, 9))
            6: len = ($urandom_range(0, 3) == 0) ? 1024 : $urandom_range(total, 1024);
            7: len = $urandom_range(1, total);
            8: begin
                n = total + $urandom_range(1, 4);
                len = (n <= 1024 && $urandom_range(0, 1) == 1) ? n : total;
            end
            9: image[$urandom_range(0, total - 1)] = rb();
            default: ;
        endcase
        send_image(len, n, noisy);
    endtask

    // only while idle: drain results, let the pipeline settle, then write
    task automatic write_reg(logic idx, logic [9:0] val);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_records.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_register(idx, val);
        reg_writes++;
    endtask

    initial begin
        int p, wait_cnt;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = ucdp_pkg::CFG_MAX_EP;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_data_byte       = '0;
        i_first_of_buffer = 1'b0;
        i_buffer_length   = 11'd1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // length byte below two, descriptor past the end, wrong first descriptor
        image = '{8'h01};
        send_image(5, 1, 1'b0);
        image = '{8'hC8};
        send_image(2, 1, 1'b0);
        image = '{8'h09, 8'hFF};
        send_image(9, 2, 1'b0);
        // short config, clamped interface, extra, endpoint, two-byte extra at the end
        image = '{8'h05, ucdp_pkg::DESC_CONFIG, 8'h00, 8'h00, 8'h01,
                  8'h05, ucdp_pkg::DESC_IFACE, 8'hFF, 8'h00, 8'hFF,
                  8'h03, 8'h24, 8'hAA,
                  8'h07, ucdp_pkg::DESC_ENDP, 8'h81, 8'h03, 8'hFF, 8'h00, 8'h01,
                  8'h02, 8'h24};
        send_image(22, 23, 1'b0);

        for (p = 0; p < 6; p++) begin
            case (p)
                1: begin
                    write_reg(ucdp_pkg::CFG_MAX_EP, {5'($urandom), 5'd1});
                    write_reg(ucdp_pkg::CFG_CAPACITY, 10'd0);
                    rx_mode = RX_RANDOM;
                    gaps_on = 1'b1;
                end
                2: begin
                    write_reg(ucdp_pkg::CFG_MAX_EP, 10'd16);
                    write_reg(ucdp_pkg::CFG_CAPACITY, 10'd1023);
                    rx_mode  = RX_ALWAYS;
                    gaps_on  = 1'b1;
                    hold_req = 1'b1;
                end
                3: begin
                    write_reg(ucdp_pkg::CFG_MAX_EP, {5'($urandom), 5'd0});
                    write_reg(ucdp_pkg::CFG_CAPACITY, 10'd12);
                    rx_mode = RX_SLOW;
                    gaps_on = 1'b1;
                end
                4: begin
                    write_reg(ucdp_pkg::CFG_MAX_EP, 10'h3FF);
                    write_reg(ucdp_pkg::CFG_CAPACITY, 10'd40);
                    rx_mode = RX_RANDOM;
                    gaps_on = 1'b0;
                end
                5: begin
                    write_reg(ucdp_pkg::CFG_MAX_EP, {5'($urandom), 5'($urandom_range(1, 16))});
                    write_reg(ucdp_pkg::CFG_CAPACITY, 10'($urandom));
                    rx_mode  = RX_PATTERN;
                    gaps_on  = 1'b1;
                    hold_req = 1'b1;
                end
                default: begin
                    rx_mode = RX_ALWAYS;
                    gaps_on = 1'b0;
                end
            endcase
            phase_bytes = 0;
            while (phase_bytes < 120) play_buffer();
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait_cnt = 0;
        while (sb.pending_records.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.pending_records.size() != 0) begin
            $error("%0d expected records never arrived", sb.pending_records.size());
            sb.mismatches++;
        end
        $display("sent %0d bytes in %0d buffers, %0d register writes, %0d receiver hold-offs",
                 bytes_sent, buffers_sent, reg_writes, hold_count);
        $display("checked %0d interface, %0d endpoint, %0d extra and %0d error records",
                 sb.seen_by_kind[ucdp_pkg::KIND_IFACE], sb.seen_by_kind[ucdp_pkg::KIND_ENDP],
                 sb.seen_by_kind[ucdp_pkg::KIND_EXTRA], sb.seen_by_kind[ucdp_pkg::KIND_ERROR]);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
